FILE: design/hms_pkg.sv
`default_nettype none
package hms_pkg;

  localparam int unsigned MaxEntries  = 64;
  localparam int unsigned MaxPrograms = 16;
  localparam int unsigned MaxAdvances = 4;

  localparam logic [15:0] NoProgram = 16'hFFFF;
  localparam logic [16:0] Q16One    = 17'h10000;
  localparam logic [63:0] AllOnes   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_COMMIT  = 3'd1,
    OP_ENABLE  = 3'd2,
    OP_DISABLE = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NO_EFFECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_OFF   = 2'd0,
    PH_HOLD  = 2'd1,
    PH_MORPH = 2'd2,
    PH_FINAL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_ENTRY_COUNT   = 2'd0,
    CFG_LOOP_START    = 2'd1,
    CFG_PROGRAM_COUNT = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  entry_index;
    logic [7:0]  from_node;
    logic [7:0]  to_node;
    logic [15:0] prog_sel;
    logic        no_morph;
    logic [63:0] hold_len;
    logic [63:0] morph_len;
    logic [63:0] frame_now;
    logic        transport_running;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  phase_now;
    logic [5:0]  current_entry;
    logic [15:0] current_program;
    logic [16:0] morph_position;
    logic        apply_pending;
    logic        prog_changed;
    logic [31:0] transitions_done;
    logic        is_running;
    logic [63:0] next_boundary;
    logic [63:0] total_frames;
    logic        final_flush;
  } result_t;

  typedef struct packed {
    logic [1:0] index;
    logic [6:0] data;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_DECODE,
    CMD_CMT_ADDR,
    CMD_CMT_HOLD,
    CMD_CMT_MORPH,
    CMD_CMT_LOOP,
    CMD_EN_ADDR,
    CMD_EN_DO,
    CMD_TK_EL,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_DONE,
    CMD_ADV_CHK,
    CMD_ADV_STEP,
    CMD_ADV_HOLD,
    CMD_RESULT
  } dp_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CMT_ADDR,
    S_CMT_HOLD,
    S_CMT_MORPH,
    S_CMT_LOOP,
    S_EN_ADDR,
    S_EN_DO,
    S_TK_EL,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_DONE,
    S_ADV_CHK,
    S_ADV_STEP,
    S_ADV_HOLD,
    S_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0] op;
    logic       cmt_pre_ok;
    logic       hold_bad;
    logic       morph_bad;
    logic       cmt_last;
    logic       armed;
    logic       tick_run;
    logic       do_div;
    logic       div_last;
    logic       adv_go;
    logic       adv_morph;
    logic       adv_finish;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/hms_if.sv
`default_nettype none
interface hms_item_if;
  import hms_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hms_result_if;
  import hms_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hms_cfg_if;
  import hms_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/hms_ctrl.sv
`default_nettype none
module hms_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  hms_pkg::dp_stat_t stat_i,
  output logic              in_ready_o,
  output hms_pkg::dp_cmd_e  cmd_o
);
  import hms_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (op_e'(stat_i.op))
          OP_COMMIT: state_d = stat_i.cmt_pre_ok ? S_CMT_ADDR : S_RESULT;
          OP_ENABLE: state_d = stat_i.armed ? S_EN_ADDR : S_RESULT;
          OP_TICK: begin
            if (!stat_i.tick_run) state_d = S_RESULT;
            else if (stat_i.do_div) state_d = S_TK_EL;
            else state_d = S_ADV_CHK;
          end
          default:   state_d = S_RESULT;
        endcase
      end
      S_CMT_ADDR:  state_d = S_CMT_HOLD;
      S_CMT_HOLD:  state_d = stat_i.hold_bad ? S_RESULT : S_CMT_MORPH;
      S_CMT_MORPH: begin
        if (stat_i.morph_bad) state_d = S_RESULT;
        else if (stat_i.cmt_last) state_d = S_CMT_LOOP;
        else state_d = S_CMT_ADDR;
      end
      S_CMT_LOOP:  state_d = S_RESULT;
      S_EN_ADDR:   state_d = S_EN_DO;
      S_EN_DO:     state_d = S_RESULT;
      S_TK_EL:     state_d = S_DIV_INIT;
      S_DIV_INIT:  state_d = S_DIV_STEP;
      S_DIV_STEP:  if (stat_i.div_last) state_d = S_DIV_DONE;
      S_DIV_DONE:  state_d = S_ADV_CHK;
      S_ADV_CHK:   state_d = stat_i.adv_go ? S_ADV_STEP : S_RESULT;
      S_ADV_STEP: begin
        if (stat_i.adv_morph) state_d = S_ADV_CHK;
        else if (stat_i.adv_finish) state_d = S_RESULT;
        else state_d = S_ADV_HOLD;
      end
      S_ADV_HOLD:  state_d = S_ADV_CHK;
      S_RESULT:    if (stat_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = CMD_LATCH;
      end
      S_DECODE:    cmd_o = CMD_DECODE;
      S_CMT_ADDR:  cmd_o = CMD_CMT_ADDR;
      S_CMT_HOLD:  cmd_o = CMD_CMT_HOLD;
      S_CMT_MORPH: cmd_o = CMD_CMT_MORPH;
      S_CMT_LOOP:  cmd_o = CMD_CMT_LOOP;
      S_EN_ADDR:   cmd_o = CMD_EN_ADDR;
      S_EN_DO:     cmd_o = CMD_EN_DO;
      S_TK_EL:     cmd_o = CMD_TK_EL;
      S_DIV_INIT:  cmd_o = CMD_DIV_INIT;
      S_DIV_STEP:  cmd_o = CMD_DIV_STEP;
      S_DIV_DONE:  cmd_o = CMD_DIV_DONE;
      S_ADV_CHK:   cmd_o = CMD_ADV_CHK;
      S_ADV_STEP:  cmd_o = CMD_ADV_STEP;
      S_ADV_HOLD:  cmd_o = CMD_ADV_HOLD;
      S_RESULT:    if (stat_i.out_free) cmd_o = CMD_RESULT;
      default:     cmd_o = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/hms_dp.sv
`default_nettype none
module hms_dp (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  hms_pkg::dp_cmd_e   cmd_i,
  input  hms_pkg::item_t     item_i,
  input  wire                cfg_valid_i,
  input  hms_pkg::cfg_t      cfg_i,
  input  wire                out_ready_i,
  output logic               out_valid_o,
  output hms_pkg::result_t   out_data_o,
  output hms_pkg::dp_stat_t  stat_o
);
  import hms_pkg::*;

  typedef struct packed {
    logic        no_morph;
    logic [15:0] prog;
    logic [7:0]  to_node;
    logic [7:0]  from_node;
  } link_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? AllOnes : s[63:0];
  endfunction

  // schedule memories
  logic [63:0] hold_mem  [MaxEntries];
  logic [63:0] morph_mem [MaxEntries];
  link_t       link_mem  [MaxEntries];
  logic [MaxEntries-1:0] written_q;
  logic [63:0] hold_rd_q, morph_rd_q;
  link_t       link_rd_q;
  logic        mem_we, rd_en;
  logic [5:0]  raddr;

  // configuration registers
  logic [6:0] cfg_count_q, cfg_loop_q;
  logic [4:0] cfg_programs_q;

  // run state
  item_t       itm_q;
  logic        armed_q, playing_q;
  logic [1:0]  phase_q;
  logic [5:0]  pos_idx_q;
  logic [15:0] prog_q;
  logic [63:0] start_q, end_q;
  logic [16:0] position_q;
  logic        pending_q, changed_q;
  logic [31:0] adv_cnt_q;
  logic [63:0] frame_sum_q;
  logic [6:0]  run_count_q, run_loop_q;
  logic [1:0]  status_q;
  logic        flush_q;
  logic [2:0]  guard_q;

  // commit walk
  logic [6:0]  cidx_q;
  logic [63:0] total_q;
  logic [7:0]  prev_to_q, loop_from_q;

  // morph position divider
  logic [63:0] dur_q, el_raw_q, r_q;
  logic        el_gt_q;
  logic [16:0] q_q;
  logic [3:0]  div_cnt_q;

  logic        out_valid_q;
  result_t     out_q;

  // combinational checks
  logic [64:0] hold_sum, morph_sum, div_shift;
  logic        prog_bad, chain_bad, div_take, take_morph, wrap_end, loop_ok;
  logic [6:0]  nxt;
  logic [5:0]  nxt_idx;

  assign hold_sum  = {1'b0, total_q} + {1'b0, hold_rd_q};
  assign morph_sum = {1'b0, total_q} + {1'b0, morph_rd_q};
  assign prog_bad  = (link_rd_q.prog != NoProgram) &&
                     (link_rd_q.prog >= {11'd0, cfg_programs_q});
  assign chain_bad = (cidx_q != 7'd0) && (link_rd_q.from_node != prev_to_q);
  assign div_shift = {r_q, 1'b0};
  assign div_take  = div_shift >= {1'b0, dur_q};
  assign take_morph = (phase_q == PH_HOLD) && !link_rd_q.no_morph && (morph_rd_q != 64'd0);
  assign nxt       = {1'b0, pos_idx_q} + 7'd1;
  assign wrap_end  = nxt >= run_count_q;
  assign nxt_idx   = wrap_end ? 6'(run_loop_q - 7'd1) : nxt[5:0];
  assign loop_ok   = (cfg_loop_q == 7'd0) ||
                     (((cfg_loop_q - 7'd1) < cfg_count_q) && (prev_to_q == loop_from_q));

  // status to the controller
  always_comb begin
    stat_o.op         = itm_q.op;
    stat_o.cmt_pre_ok = (cfg_count_q != 7'd0) && (cfg_count_q <= 7'(MaxEntries)) &&
                        (cfg_programs_q <= 5'(MaxPrograms));
    stat_o.hold_bad   = !written_q[cidx_q[5:0]] || (hold_rd_q == 64'd0) || prog_bad ||
                        chain_bad || hold_sum[64];
    stat_o.morph_bad  = morph_sum[64];
    stat_o.cmt_last   = (cidx_q + 7'd1) >= cfg_count_q;
    stat_o.armed      = armed_q;
    stat_o.tick_run   = playing_q && itm_q.transport_running;
    stat_o.do_div     = (phase_q == PH_MORPH) && (end_q > start_q);
    stat_o.div_last   = div_cnt_q == 4'd15;
    stat_o.adv_go     = (guard_q < 3'(MaxAdvances)) && (itm_q.frame_now >= end_q);
    stat_o.adv_morph  = take_morph;
    stat_o.adv_finish = wrap_end && (run_loop_q == 7'd0);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // memory port control
  always_comb begin
    mem_we = (cmd_i == CMD_DECODE) && (op_e'(itm_q.op) == OP_WRITE) && !playing_q &&
             ({1'b0, itm_q.entry_index} < cfg_count_q);
    rd_en  = 1'b0;
    raddr  = pos_idx_q;
    case (cmd_i)
      CMD_CMT_ADDR: begin
        rd_en = 1'b1;
        raddr = cidx_q[5:0];
      end
      CMD_EN_ADDR: begin
        rd_en = 1'b1;
        raddr = 6'd0;
      end
      CMD_ADV_CHK:  rd_en = 1'b1;
      CMD_ADV_STEP: begin
        rd_en = !take_morph;
        raddr = nxt_idx;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hold_mem[itm_q.entry_index]  <= itm_q.hold_len;
      morph_mem[itm_q.entry_index] <= itm_q.morph_len;
      link_mem[itm_q.entry_index]  <= '{no_morph: itm_q.no_morph, prog: itm_q.prog_sel,
                                        to_node: itm_q.to_node, from_node: itm_q.from_node};
    end
    if (rd_en) begin
      hold_rd_q  <= hold_mem[raddr];
      morph_rd_q <= morph_mem[raddr];
      link_rd_q  <= link_mem[raddr];
    end
  end

  // item latch, divider and commit working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH:  itm_q <= item_i;
      CMD_DECODE: begin
        cidx_q  <= 7'd0;
        total_q <= 64'd0;
      end
      CMD_CMT_HOLD: begin
        total_q   <= hold_sum[63:0];
        prev_to_q <= link_rd_q.to_node;
        if (cidx_q == cfg_loop_q - 7'd1) loop_from_q <= link_rd_q.from_node;
      end
      CMD_CMT_MORPH: begin
        total_q <= morph_sum[63:0];
        cidx_q  <= cidx_q + 7'd1;
      end
      CMD_TK_EL: begin
        dur_q    <= end_q - start_q;
        el_raw_q <= itm_q.frame_now - start_q;
        el_gt_q  <= itm_q.frame_now > start_q;
      end
      CMD_DIV_INIT: begin
        // elapsed clamps to the duration, whole quotient bit then zero remainder
        q_q       <= {16'd0, el_gt_q && (el_raw_q >= dur_q)};
        r_q       <= (el_gt_q && (el_raw_q < dur_q)) ? el_raw_q : 64'd0;
        div_cnt_q <= 4'd0;
      end
      CMD_DIV_STEP: begin
        r_q       <= div_take ? 64'(div_shift - {1'b0, dur_q}) : div_shift[63:0];
        q_q       <= {q_q[15:0], div_take};
        div_cnt_q <= div_cnt_q + 4'd1;
      end
      default: ;
    endcase
  end

  // control and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q      <= '0;
      cfg_count_q    <= 7'd1;
      cfg_loop_q     <= 7'd0;
      cfg_programs_q <= 5'd0;
      armed_q        <= 1'b0;
      playing_q      <= 1'b0;
      phase_q        <= PH_OFF;
      pos_idx_q      <= 6'd0;
      prog_q         <= NoProgram;
      start_q        <= 64'd0;
      end_q          <= 64'd0;
      position_q     <= 17'd0;
      pending_q      <= 1'b0;
      changed_q      <= 1'b0;
      adv_cnt_q      <= 32'd0;
      frame_sum_q    <= 64'd0;
      run_count_q    <= 7'd1;
      run_loop_q     <= 7'd0;
      status_q       <= ST_OK;
      flush_q        <= 1'b0;
      guard_q        <= 3'd0;
      out_valid_q    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid_i) begin
        case (cfg_index_e'(cfg_i.index))
          CFG_ENTRY_COUNT:   cfg_count_q    <= cfg_i.data;
          CFG_LOOP_START:    cfg_loop_q     <= cfg_i.data;
          CFG_PROGRAM_COUNT: cfg_programs_q <= cfg_i.data[4:0];
          default: ;
        endcase
      end
      // result handshake
      if (cmd_i == CMD_RESULT) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i)
        CMD_LATCH: begin
          status_q <= ST_OK;
          flush_q  <= 1'b0;
        end
        CMD_DECODE: begin
          case (op_e'(itm_q.op))
            OP_WRITE: begin
              if (playing_q) status_q <= ST_INVALID;
              else if (!mem_we) status_q <= ST_NO_EFFECT;
              else begin
                written_q[itm_q.entry_index] <= 1'b1;
                armed_q <= 1'b0;
              end
            end
            OP_COMMIT: if (!stat_o.cmt_pre_ok) status_q <= ST_INVALID;
            OP_ENABLE: if (!armed_q) status_q <= ST_INVALID;
            OP_DISABLE: begin
              playing_q <= 1'b0;
              phase_q   <= PH_OFF;
              pending_q <= 1'b0;
            end
            OP_TICK: begin
              if (!stat_o.tick_run) status_q <= ST_NO_EFFECT;
              else begin
                pending_q <= 1'b0;
                changed_q <= 1'b0;
                guard_q   <= 3'd0;
              end
            end
            default: status_q <= ST_INVALID;
          endcase
        end
        CMD_CMT_HOLD:  if (stat_o.hold_bad) status_q <= ST_INVALID;
        CMD_CMT_MORPH: if (stat_o.morph_bad) status_q <= ST_INVALID;
        CMD_CMT_LOOP: begin
          if (loop_ok) begin
            frame_sum_q <= total_q;
            run_count_q <= cfg_count_q;
            run_loop_q  <= cfg_loop_q;
            armed_q     <= 1'b1;
            playing_q   <= 1'b0;
            phase_q     <= PH_OFF;
          end else begin
            status_q <= ST_INVALID;
          end
        end
        CMD_EN_DO: begin
          pos_idx_q  <= 6'd0;
          prog_q     <= NoProgram;
          adv_cnt_q  <= 32'd0;
          phase_q    <= PH_HOLD;
          start_q    <= itm_q.frame_now;
          end_q      <= sat_add(itm_q.frame_now, hold_rd_q);
          position_q <= 17'd0;
          pending_q  <= 1'b0;
          changed_q  <= 1'b0;
          playing_q  <= 1'b1;
        end
        CMD_DIV_DONE: begin
          if (q_q != position_q) begin
            position_q <= q_q;
            pending_q  <= prog_q != NoProgram;
          end
        end
        CMD_ADV_STEP: begin
          if (take_morph) begin
            phase_q    <= PH_MORPH;
            start_q    <= end_q;
            end_q      <= sat_add(end_q, morph_rd_q);
            prog_q     <= link_rd_q.prog;
            position_q <= 17'd0;
            pending_q  <= link_rd_q.prog != NoProgram;
            changed_q  <= link_rd_q.prog != NoProgram;
            guard_q    <= guard_q + 3'd1;
          end else begin
            if (phase_q == PH_MORPH) position_q <= Q16One;
            adv_cnt_q <= adv_cnt_q + 32'd1;
            start_q   <= end_q;
            if (stat_o.adv_finish) begin
              // schedule ends in final hold
              flush_q   <= 1'b1;
              playing_q <= 1'b0;
              phase_q   <= PH_FINAL;
              end_q     <= AllOnes;
              pending_q <= 1'b0;
              changed_q <= 1'b0;
            end else begin
              if (phase_q == PH_MORPH) pending_q <= prog_q != NoProgram;
              pos_idx_q <= nxt_idx;
              phase_q   <= PH_HOLD;
            end
          end
        end
        CMD_ADV_HOLD: begin
          end_q   <= sat_add(start_q, hold_rd_q);
          guard_q <= guard_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_RESULT) begin
      out_q.status           <= status_q;
      out_q.phase_now        <= phase_q;
      out_q.current_entry    <= pos_idx_q;
      out_q.current_program  <= prog_q;
      out_q.morph_position   <= position_q;
      out_q.apply_pending    <= pending_q;
      out_q.prog_changed     <= changed_q;
      out_q.transitions_done <= adv_cnt_q;
      out_q.is_running       <= playing_q;
      out_q.next_boundary    <= (!playing_q || !itm_q.transport_running ||
                                 (phase_q == PH_FINAL)) ? AllOnes : end_q;
      out_q.total_frames     <= frame_sum_q;
      out_q.final_flush      <= flush_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: design/hold_morph_schedule_sequencer.sv
`default_nettype none
// channel    | dir | handshake    | payload
// in_chan    | in  | valid/ready  | op, entry fields, frame_now, transport_running
// out_chan   | out | valid/ready  | status, phase, position, counters, boundaries
// cfg_chan   | in  | valid/ready  | register index (2 bits), data (7 bits)
//
// one transaction at a time: a commit visits every entry in use, and a running tick steps
// through each boundary crossed, first running the bit-serial morph position divider
// when in morph.
// the schedule memory has one read port, so entries are visited one per step.
// rst_ni clears control state and entry written bits at once, no clearing pass.
// a waiting result stalls only the finishing cycle; cfg_chan is always ready.
module hold_morph_schedule_sequencer (
  input  wire           clk_i,
  input  wire           rst_ni,
  hms_item_if.sink      in_chan,
  hms_result_if.source  out_chan,
  hms_cfg_if.sink       cfg_chan
);
  import hms_pkg::*;

  dp_cmd_e  cmd;
  dp_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  // sequencing controller
  hms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .stat_i     (stat),
    .in_ready_o (in_chan.ready),
    .cmd_o      (cmd)
  );

  // schedule store and run datapath
  hms_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (in_chan.data),
    .cfg_valid_i (cfg_chan.valid),
    .cfg_i       (cfg_chan.data),
    .out_ready_i (out_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_data_o  (out_chan.data),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire

FILE: dv/tb_hold_morph_schedule_sequencer.sv
`default_nettype none
module tb_hold_morph_schedule_sequencer;
  import hms_pkg::*;

  logic clk_i;
  logic rst_ni;

  hms_item_if   in_chan ();
  hms_result_if out_chan ();
  hms_cfg_if    cfg_chan ();

  hold_morph_schedule_sequencer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // idle percentages of each side
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned finishes_seen;
  int unsigned morph_ticks_seen;

  result_t expected_results[$];

  // sequencer shadow state
  logic [63:0] sh_hold [MaxEntries];
  logic [63:0] sh_morph[MaxEntries];
  logic [7:0]  sh_from [MaxEntries];
  logic [7:0]  sh_to   [MaxEntries];
  logic [15:0] sh_prog [MaxEntries];
  logic        sh_self [MaxEntries];
  logic        sh_written[MaxEntries];
  logic        sh_armed, sh_playing;
  phase_e      sh_phase;
  logic [5:0]  sh_pos_idx;
  logic [15:0] sh_program;
  logic [63:0] sh_start, sh_end;
  logic [16:0] sh_position;
  logic        sh_pending, sh_changed;
  logic [31:0] sh_advances;
  logic [63:0] sh_frame_sum;
  logic [6:0]  reg_count, reg_loop;
  logic [4:0]  reg_programs;
  logic [6:0]  run_count, run_loop;

  task automatic reset_shadow();
    for (int i = 0; i < MaxEntries; i++) begin
      sh_hold[i] = '0;
      sh_morph[i] = '0;
      sh_from[i] = '0;
      sh_to[i] = '0;
      sh_prog[i] = '0;
      sh_self[i] = 1'b0;
      sh_written[i] = 1'b0;
    end
    sh_armed = 1'b0;
    sh_playing = 1'b0;
    sh_phase = PH_OFF;
    sh_pos_idx = '0;
    sh_program = NoProgram;
    sh_start = '0;
    sh_end = '0;
    sh_position = '0;
    sh_pending = 1'b0;
    sh_changed = 1'b0;
    sh_advances = '0;
    sh_frame_sum = '0;
    reg_count = 7'd1;
    reg_loop = '0;
    reg_programs = '0;
    run_count = 7'd1;
    run_loop = '0;
  endtask

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? AllOnes : s[63:0];
  endfunction

  // restoring divide giving floor(elapsed * 2^16 / duration)
  function automatic logic [16:0] morph_fraction(logic [63:0] elapsed, logic [63:0] duration);
    logic [16:0] q;
    logic [63:0] r;
    logic        carry;
    q = (elapsed >= duration) ? 17'd1 : 17'd0;
    r = (elapsed >= duration) ? elapsed - duration : elapsed;
    for (int k = 0; k < 16; k++) begin
      carry = r[63];
      r = r << 1;
      q = q << 1;
      if (carry || r >= duration) begin
        r = r - duration;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic table_valid(output logic [63:0] sum);
    logic [64:0] total;
    total = '0;
    sum = '0;
    if (reg_count == 0 || reg_count > MaxEntries) return 1'b0;
    if (reg_programs > MaxPrograms) return 1'b0;
    for (int i = 0; i < reg_count; i++) begin
      if (!sh_written[i] || sh_hold[i] == 0) return 1'b0;
      if (sh_prog[i] != NoProgram && sh_prog[i] >= reg_programs) return 1'b0;
      total = total + sh_hold[i];
      if (total[64]) return 1'b0;
      total = total + sh_morph[i];
      if (total[64]) return 1'b0;
      if (i + 1 < reg_count && sh_to[i] != sh_from[i + 1]) return 1'b0;
    end
    if (reg_loop != 0) begin
      if (reg_loop - 1 >= reg_count) return 1'b0;
      if (sh_to[reg_count - 1] != sh_from[reg_loop - 1]) return 1'b0;
    end
    sum = total[63:0];
    return 1'b1;
  endfunction

  // works out the result of one accepted transaction and updates the shadow
  function automatic result_t sequence_step(item_t it);
    result_t     r;
    status_e     st;
    logic        flush;
    logic [63:0] sum, dur, el;
    logic [16:0] pos;
    int          cur, nxt;
    st = ST_OK;
    flush = 1'b0;
    case (it.op)
      OP_WRITE: begin
        if (sh_playing) st = ST_INVALID;
        else if (it.entry_index >= reg_count) st = ST_NO_EFFECT;
        else begin
          sh_from[it.entry_index] = it.from_node;
          sh_to[it.entry_index] = it.to_node;
          sh_prog[it.entry_index] = it.prog_sel;
          sh_self[it.entry_index] = it.no_morph;
          sh_written[it.entry_index] = 1'b1;
          sh_hold[it.entry_index] = it.hold_len;
          sh_morph[it.entry_index] = it.morph_len;
          sh_armed = 1'b0;
        end
      end
      OP_COMMIT: begin
        if (table_valid(sum)) begin
          sh_frame_sum = sum;
          run_count = reg_count;
          run_loop = reg_loop;
          sh_armed = 1'b1;
          sh_playing = 1'b0;
          sh_phase = PH_OFF;
        end else st = ST_INVALID;
      end
      OP_ENABLE: begin
        if (!sh_armed) st = ST_INVALID;
        else begin
          sh_pos_idx = '0;
          sh_program = NoProgram;
          sh_advances = '0;
          sh_phase = PH_HOLD;
          sh_start = it.frame_now;
          sh_end = sat_add(it.frame_now, sh_hold[0]);
          sh_position = '0;
          sh_pending = 1'b0;
          sh_changed = 1'b0;
          sh_playing = 1'b1;
        end
      end
      OP_DISABLE: begin
        sh_playing = 1'b0;
        sh_phase = PH_OFF;
        sh_pending = 1'b0;
      end
      OP_TICK: begin
        if (!sh_playing || !it.transport_running) st = ST_NO_EFFECT;
        else begin
          sh_pending = 1'b0;
          sh_changed = 1'b0;
          if (sh_phase == PH_MORPH && sh_end > sh_start) begin
            morph_ticks_seen++;
            dur = sh_end - sh_start;
            el = '0;
            if (it.frame_now > sh_start) begin
              el = it.frame_now - sh_start;
              if (el > dur) el = dur;
            end
            pos = morph_fraction(el, dur);
            if (pos != sh_position) begin
              sh_position = pos;
              sh_pending = sh_program != NoProgram;
            end
          end
          for (int g = 0; g < MaxAdvances && it.frame_now >= sh_end; g++) begin
            cur = sh_pos_idx;
            if (sh_phase == PH_HOLD) begin
              if (!sh_self[cur] && sh_morph[cur] > 0) begin
                sh_phase = PH_MORPH;
                sh_start = sh_end;
                sh_end = sat_add(sh_start, sh_morph[cur]);
                sh_program = sh_prog[cur];
                sh_position = '0;
                sh_pending = sh_program != NoProgram;
                sh_changed = sh_pending;
                continue;
              end
            end else if (sh_phase == PH_MORPH) begin
              sh_position = Q16One;
              sh_pending = sh_program != NoProgram;
            end
            sh_advances++;
            nxt = cur + 1;
            if (nxt >= run_count) begin
              if (run_loop == 0) begin
                flush = 1'b1;
                finishes_seen++;
                sh_playing = 1'b0;
                sh_phase = PH_FINAL;
                sh_start = sh_end;
                sh_end = AllOnes;
                sh_pending = 1'b0;
                sh_changed = 1'b0;
                break;
              end
              nxt = run_loop - 1;
            end
            sh_pos_idx = 6'(nxt);
            sh_phase = PH_HOLD;
            sh_start = sh_end;
            sh_end = sat_add(sh_start, sh_hold[sh_pos_idx]);
          end
        end
      end
      default: st = ST_INVALID;
    endcase
    r.status = st;
    r.phase_now = sh_phase;
    r.current_entry = sh_pos_idx;
    r.current_program = sh_program;
    r.morph_position = sh_position;
    r.apply_pending = sh_pending;
    r.prog_changed = sh_changed;
    r.transitions_done = sh_advances;
    r.is_running = sh_playing;
    r.next_boundary = (!sh_playing || !it.transport_running || sh_phase == PH_FINAL) ?
                      AllOnes : sh_end;
    r.total_frames = sh_frame_sum;
    r.final_flush = flush;
    return r;
  endfunction

  // result checking
  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no transaction outstanding: %p", got);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    results_seen++;
    if (got.status !== want.status) begin
      $error("status exp %0d got %0d", want.status, got.status); fail_count++;
    end
    if (got.phase_now !== want.phase_now) begin
      $error("phase_now exp %0d got %0d", want.phase_now, got.phase_now); fail_count++;
    end
    if (got.current_entry !== want.current_entry) begin
      $error("current_entry exp %0d got %0d", want.current_entry, got.current_entry);
      fail_count++;
    end
    if (got.current_program !== want.current_program) begin
      $error("current_program exp %0h got %0h", want.current_program, got.current_program);
      fail_count++;
    end
    if (got.morph_position !== want.morph_position) begin
      $error("morph_position exp %0h got %0h", want.morph_position, got.morph_position);
      fail_count++;
    end
    if (got.apply_pending !== want.apply_pending) begin
      $error("apply_pending exp %0b got %0b", want.apply_pending, got.apply_pending);
      fail_count++;
    end
    if (got.prog_changed !== want.prog_changed) begin
      $error("prog_changed exp %0b got %0b", want.prog_changed, got.prog_changed);
      fail_count++;
    end
    if (got.transitions_done !== want.transitions_done) begin
      $error("transitions_done exp %0d got %0d", want.transitions_done, got.transitions_done);
      fail_count++;
    end
    if (got.is_running !== want.is_running) begin
      $error("is_running exp %0b got %0b", want.is_running, got.is_running); fail_count++;
    end
    if (got.next_boundary !== want.next_boundary) begin
      $error("next_boundary exp %0h got %0h", want.next_boundary, got.next_boundary);
      fail_count++;
    end
    if (got.total_frames !== want.total_frames) begin
      $error("total_frames exp %0h got %0h", want.total_frames, got.total_frames);
      fail_count++;
    end
    if (got.final_flush !== want.final_flush) begin
      $error("final_flush exp %0b got %0b", want.final_flush, got.final_flush); fail_count++;
    end
  endtask

  // result side: random back-pressure and checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_result(out_chan.data);
      out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // sends one transaction; called at a rising edge
  task automatic send_item(item_t it);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= it;
    do @(posedge clk_i); while (!in_chan.ready);
    expected_results.push_back(sequence_step(it));
    items_sent++;
  endtask

  function automatic item_t ctl_item(logic [2:0] op, logic [63:0] frame, logic running);
    item_t it;
    it.op = op;
    it.entry_index = 6'($urandom());
    it.from_node = 8'($urandom());
    it.to_node = 8'($urandom());
    it.prog_sel = 16'($urandom());
    it.no_morph = 1'($urandom());
    it.hold_len = rand64();
    it.morph_len = rand64();
    it.frame_now = frame;
    it.transport_running = running;
    return it;
  endfunction

  task automatic send_write(int idx, logic [7:0] from_n, logic [7:0] to_n, logic [15:0] prog,
                            logic self_l, logic [63:0] hold, logic [63:0] morph);
    item_t it;
    it = ctl_item(OP_WRITE, rand64(), 1'($urandom()));
    it.entry_index = 6'(idx);
    it.from_node = from_n;
    it.to_node = to_n;
    it.prog_sel = prog;
    it.no_morph = self_l;
    it.hold_len = hold;
    it.morph_len = morph;
    send_item(it);
  endtask

  task automatic send_ctl(op_e op, logic [63:0] frame, logic running = 1'b1);
    send_item(ctl_item(op, frame, running));
  endtask

  // holds the sender until every outstanding result is back
  task automatic drain();
    int unsigned guard;
    in_chan.valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // register write, only while idle
  task automatic cfg_write(cfg_index_e idx, logic [6:0] value);
    drain();
    cfg_chan.valid <= 1'b1;
    cfg_chan.data <= '{index: idx, data: value};
    do @(posedge clk_i); while (!cfg_chan.ready);
    case (idx)
      CFG_ENTRY_COUNT:   reg_count = value;
      CFG_LOOP_START:    reg_loop = value;
      CFG_PROGRAM_COUNT: reg_programs = value[4:0];
      default: ;
    endcase
    cfg_chan.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(int count, int loop_to, int programs);
    cfg_write(CFG_ENTRY_COUNT, 7'(count));
    cfg_write(CFG_LOOP_START, 7'(loop_to));
    cfg_write(CFG_PROGRAM_COUNT, 7'(programs));
  endtask

  // rejected and ignored requests on a fresh block
  task automatic test_rejections();
    send_ctl(OP_COMMIT, '0);
    send_ctl(OP_ENABLE, '0);
    send_ctl(OP_TICK, '0);
    send_ctl(OP_DISABLE, AllOnes);
    for (int k = 1; k <= 3; k++) send_item(ctl_item(3'(OP_TICK + k), rand64(), 1'b1));
    send_write(1, 8'h00, 8'hFF, NoProgram, 1'b0, 64'd5, 64'd0);
  endtask

  // commit checks fail one at a time, then a clean table commits
  task automatic test_commit_checks();
    set_config(3, 0, 16);
    send_write(0, 8'd1, 8'd2, 16'd0, 1'b0, 64'd4, 64'd4);
    send_write(1, 8'd2, 8'd3, 16'd15, 1'b0, 64'd0, 64'd4);
    send_ctl(OP_COMMIT, '0);
    send_write(1, 8'd2, 8'd3, 16'd16, 1'b0, 64'd3, 64'd4);
    send_write(2, 8'd3, 8'd4, NoProgram, 1'b1, 64'd3, 64'd0);
    send_ctl(OP_COMMIT, '0);
    send_write(1, 8'd9, 8'd3, 16'd15, 1'b0, 64'd3, 64'd4);
    send_ctl(OP_COMMIT, '0);
    send_write(1, 8'd2, 8'd3, 16'd15, 1'b0, AllOnes, 64'd4);
    send_ctl(OP_COMMIT, '0);
    send_write(1, 8'd2, 8'd3, 16'd15, 1'b0, 64'd3, 64'd4);
    cfg_write(CFG_LOOP_START, 7'd4);
    send_ctl(OP_COMMIT, '0);
    cfg_write(CFG_LOOP_START, 7'd2);
    send_ctl(OP_COMMIT, '0);
    cfg_write(CFG_LOOP_START, 7'd0);
    cfg_write(CFG_PROGRAM_COUNT, 7'd17);
    send_ctl(OP_COMMIT, '0);
    cfg_write(CFG_PROGRAM_COUNT, 7'd16);
    send_ctl(OP_COMMIT, '0);
  endtask

  // plays the committed table through hold, morph, self loop and finish
  task automatic test_playback();
    send_ctl(OP_ENABLE, 64'd100);
    send_write(0, 8'd1, 8'd2, 16'd0, 1'b0, 64'd4, 64'd4);
    send_ctl(OP_TICK, 64'd104, 1'b0);
    send_ctl(OP_TICK, 64'd104);
    send_ctl(OP_TICK, 64'd106);
    send_ctl(OP_TICK, 64'd107);
    send_ctl(OP_TICK, 64'd200);
    send_ctl(OP_ENABLE, 64'd0);
    send_ctl(OP_DISABLE, 64'd0);
    send_ctl(OP_TICK, 64'd50);
  endtask

  // loop wrap, max advances per tick, saturating boundaries, full table
  task automatic test_loop_and_limits();
    set_config(2, 1, 0);
    send_write(0, 8'd7, 8'd8, NoProgram, 1'b0, 64'd1, 64'd1);
    send_write(1, 8'd8, 8'd7, NoProgram, 1'b0, 64'd1, 64'd1);
    send_ctl(OP_COMMIT, '0);
    send_ctl(OP_ENABLE, 64'd0);
    send_ctl(OP_TICK, 64'd1000);
    send_ctl(OP_ENABLE, AllOnes - 64'd2);
    send_ctl(OP_TICK, AllOnes);
    send_ctl(OP_TICK, AllOnes);
    set_config(64, 64, 0);
    for (int i = 0; i < MaxEntries; i++)
      send_write(i, 8'd0, 8'd0, NoProgram, 1'($urandom()), 64'd1, 64'($urandom_range(0, 1)));
    send_ctl(OP_COMMIT, '0);
    send_ctl(OP_ENABLE, 64'd0);
    send_ctl(OP_TICK, 64'd3);
    send_ctl(OP_DISABLE, '0);
  endtask

  function automatic logic [63:0] pick_hold();
    int unsigned d;
    d = $urandom_range(99);
    if (d < 3) return '0;
    if (d < 8) return rand64();
    return 64'($urandom_range(1, 60));
  endfunction

  function automatic logic [63:0] pick_morph();
    int unsigned d;
    d = $urandom_range(99);
    if (d < 35) return '0;
    if (d < 40) return rand64() >> $urandom_range(0, 63);
    return 64'($urandom_range(1, 80));
  endfunction

  // one random schedule: configure, load, commit, play with some noise
  task automatic random_schedule();
    int          count, loop_to, programs, ticks;
    logic [7:0]  nodes[65];
    logic [15:0] prog;
    logic [63:0] frame;
    count = ($urandom_range(99) < 90) ? $urandom_range(1, 6) : $urandom_range(7, 64);
    loop_to = ($urandom_range(1) != 0) ? $urandom_range(1, count) : 0;
    programs = ($urandom_range(99) < 5) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    if ($urandom_range(99) < 3) count = $urandom_range(0, 127);
    set_config(count, loop_to, programs);
    if (count == 0 || count > MaxEntries) begin
      send_ctl(OP_COMMIT, '0);
      return;
    end
    for (int i = 0; i <= count; i++) nodes[i] = 8'($urandom());
    if (loop_to != 0) nodes[count] = nodes[loop_to - 1];
    for (int i = 0; i < count; i++) begin
      prog = NoProgram;
      if ($urandom_range(1) != 0)
        prog = ($urandom_range(99) < 5) ? 16'($urandom()) : 16'($urandom_range(0, programs));
      send_write(i, nodes[i], ($urandom_range(99) < 3) ? 8'($urandom()) : nodes[i + 1],
                 prog, $urandom_range(99) < 20, pick_hold(), pick_morph());
      if ($urandom_range(99) < 4)
        send_write($urandom_range(count, 63), 8'($urandom()), 8'($urandom()),
                   16'($urandom()), 1'($urandom()), rand64(), rand64());
    end
    send_ctl(OP_COMMIT, '0);
    frame = ($urandom_range(99) < 10) ? rand64() : 64'($urandom_range(0, 1000));
    send_ctl(OP_ENABLE, frame);
    ticks = $urandom_range(5, 30);
    for (int t = 0; t < ticks; t++) begin
      case ($urandom_range(19))
        0: send_ctl(OP_DISABLE, rand64());
        1: send_ctl(OP_ENABLE, frame);
        2: send_write($urandom_range(0, count - 1), 8'($urandom()), 8'($urandom()),
                      16'($urandom()), 1'($urandom()), rand64(), rand64());
        3: send_item(ctl_item(3'($urandom_range(5, 7)), rand64(), 1'b1));
        default: begin
          frame = frame + 64'($urandom_range(0, 40));
          send_ctl(OP_TICK, frame, $urandom_range(99) < 90);
        end
      endcase
    end
  endtask

  // random schedules under each idling pattern
  task automatic test_random_schedules();
    int unsigned target;
    target = items_sent + 840;
    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 34 : (p == 1) ? 64 : 0;
      sink_idle_pct = (p == 0) ? 64 : (p == 1) ? 34 : 0;
      while (items_sent < target - (2 - p) * 280) random_schedule();
    end
  endtask

  // watchdog
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned guard;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    items_sent = 0;
    results_seen = 0;
    fail_count = 0;
    finishes_seen = 0;
    morph_ticks_seen = 0;
    reset_shadow();
    rst_ni <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rejections();
    test_commit_checks();
    test_playback();
    test_loop_and_limits();
    test_random_schedules();

    in_chan.valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (250) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    $display("%0d transactions sent, %0d results checked", items_sent, results_seen);
    $display("%0d schedules finished, %0d morph position updates", finishes_seen,
             morph_ticks_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
